/* sv/sha512mp_pkg.sv */
`default_nettype none

package sha512mp_pkg;

    // width of the saturating byte counter
    localparam int COUNT_BITS = 61;

    localparam int WORD_BITS = 64;
    localparam int BUF_BITS  = 56;
    localparam int FILL_BITS = 3;
    localparam int POS_BITS  = 8;

    // padding constants
    localparam logic [7:0]           PAD_MARK      = 8'h80;
    localparam logic [7:0]           PAD_ZERO      = 8'h00;
    localparam logic [POS_BITS-1:0]  LEN_POS       = 8'd112;
    localparam logic [POS_BITS-1:0]  LEN_POS_NEXT  = 8'd240;
    localparam logic [FILL_BITS-1:0] FILL_LAST     = 3'd7;
    // counter bits [6:3] that put a full word at position 104
    localparam logic [3:0]           OVF_GROUP     = 4'd13;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic push_pad;
        logic pad_mark;
        logic emit_hi;
        logic emit_lo;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic pad_last;
    } t_status;

endpackage

`default_nettype wire

/* sv/sha512mp_ifs.sv */
`default_nettype none

// input channel: one message byte per word
interface sha512mp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_msg;

    modport source (output valid, output msg_byte, output byte_present,
                    output end_of_msg, input ready);
    modport sink   (input valid, input msg_byte, input byte_present,
                    input end_of_msg, output ready);
endinterface

// output channel: one padded 64-bit word per word
interface sha512mp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] padded_word;
    logic        final_word;

    modport source (output valid, output padded_word, output final_word,
                    input ready);
    modport sink   (input valid, input padded_word, input final_word,
                    output ready);
endinterface

`default_nettype wire

/* sv/sha512mp_ctrl.sv */
`default_nettype none

module sha512mp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_end_of_msg,
    output logic                      o_in_ready,
    input  wire sha512mp_pkg::t_status i_st,
    output sha512mp_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_LEN_HI,
        S_LEN_LO
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   n_first;
    logic   accept;

    // command decode
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_first    = r_first;
        accept     = i_in_valid && i_st.slot_free;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = i_st.slot_free;
                o_cmd.load_in = accept;
                if (accept && i_end_of_msg) begin
                    n_state = S_PAD;
                    n_first = 1'b1;
                end
            end
            S_PAD: begin
                o_cmd.push_pad = i_st.slot_free;
                o_cmd.pad_mark = r_first;
                if (i_st.slot_free) begin
                    n_first = 1'b0;
                    if (i_st.pad_last) begin
                        n_state = S_LEN_HI;
                    end
                end
            end
            S_LEN_HI: begin
                o_cmd.emit_hi = i_st.slot_free;
                if (i_st.slot_free) begin
                    n_state = S_LEN_LO;
                end
            end
            S_LEN_LO: begin
                o_cmd.emit_lo = i_st.slot_free;
                if (i_st.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

/* sv/sha512mp_dp.sv */
`default_nettype none

module sha512mp_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_msg_byte,
    input  wire logic                 i_byte_present,
    input  wire logic                 i_end_of_msg,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [63:0]               o_padded_word,
    output logic                      o_final_word,
    input  wire sha512mp_pkg::t_cmd   i_cmd,
    output sha512mp_pkg::t_status     o_st
);

    localparam int CB = sha512mp_pkg::COUNT_BITS;
    localparam int PB = sha512mp_pkg::POS_BITS;
    localparam int FB = sha512mp_pkg::FILL_BITS;
    localparam int BB = sha512mp_pkg::BUF_BITS;
    localparam int WB = sha512mp_pkg::WORD_BITS;

    logic [CB-1:0] r_count, n_count;
    logic [BB-1:0] r_buf, n_buf;
    logic [FB-1:0] r_fill, n_fill;
    logic [PB-1:0] r_pos, n_pos;
    logic          r_tgt_hi, n_tgt_hi;
    logic          r_out_valid, n_out_valid;
    logic [WB-1:0] r_out_word, n_out_word;
    logic          r_out_final, n_out_final;

    logic          slot_free;
    logic          ovf;
    logic          push_en;
    logic [7:0]    push_val;
    logic          word_full;
    logic          cnt_inc;
    logic [PB-1:0] tgt;

    assign slot_free = !r_out_valid || i_out_ready;
    assign tgt       = r_tgt_hi ? sha512mp_pkg::LEN_POS_NEXT : sha512mp_pkg::LEN_POS;

    // end byte that would complete the word at position 104 is dropped
    assign ovf = i_end_of_msg && (r_fill == sha512mp_pkg::FILL_LAST)
                 && (r_count[6:3] == sha512mp_pkg::OVF_GROUP);

    // byte push source select
    always_comb begin
        push_en  = 1'b0;
        push_val = sha512mp_pkg::PAD_ZERO;
        if (i_cmd.load_in) begin
            push_en  = i_byte_present && !ovf;
            push_val = i_msg_byte;
        end else if (i_cmd.push_pad) begin
            push_en  = 1'b1;
            push_val = i_cmd.pad_mark ? sha512mp_pkg::PAD_MARK : sha512mp_pkg::PAD_ZERO;
        end
        word_full = push_en && (r_fill == sha512mp_pkg::FILL_LAST);
        cnt_inc   = i_cmd.load_in && push_en && (r_count != {CB{1'b1}});
    end

    // packing, counting and position tracking
    always_comb begin
        n_fill   = push_en ? r_fill + FB'(1) : r_fill;
        n_buf    = r_buf;
        if (push_en) begin
            n_buf = word_full ? '0 : {r_buf[BB-9:0], push_val};
        end
        n_count  = r_count + CB'(cnt_inc);
        n_pos    = r_pos;
        n_tgt_hi = r_tgt_hi;
        if (i_cmd.load_in) begin
            n_pos    = {1'b0, n_count[6:3], n_fill};
            n_tgt_hi = (n_pos >= sha512mp_pkg::LEN_POS);
        end else if (i_cmd.push_pad) begin
            n_pos = r_pos + PB'(1);
        end
        if (i_cmd.emit_lo) begin
            n_count = '0;
            n_fill  = '0;
            n_buf   = '0;
        end
    end

    // output word register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        n_out_final = r_out_final;
        if (word_full) begin
            n_out_valid = 1'b1;
            n_out_word  = {r_buf, push_val};
            n_out_final = 1'b0;
        end else if (i_cmd.emit_hi) begin
            n_out_valid = 1'b1;
            n_out_word  = '0;
            n_out_final = 1'b0;
        end else if (i_cmd.emit_lo) begin
            n_out_valid = 1'b1;
            n_out_word  = WB'({r_count, 3'b000});
            n_out_final = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fill      <= '0;
            r_buf       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_buf       <= n_buf;
            r_out_valid <= n_out_valid;
        end
        r_pos       <= n_pos;
        r_tgt_hi    <= n_tgt_hi;
        r_out_word  <= n_out_word;
        r_out_final <= n_out_final;
    end

    assign o_out_valid   = r_out_valid;
    assign o_padded_word = r_out_word;
    assign o_final_word  = r_out_final;
    assign o_st.slot_free = slot_free;
    assign o_st.pad_last  = (r_pos + PB'(1)) == tgt;

    // a completed word only lands in a free output slot
    a_word_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_full |-> slot_free)
        else $error("word completed while output slot busy");

    // padding never runs past the length position
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_pad |-> r_pos < tgt)
        else $error("padding past length position");

    // length words start on a word boundary
    a_len_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_hi |-> r_fill == '0)
        else $error("length word not aligned");

    // state is cleared after the final word
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_lo |=> (r_count == '0) && (r_fill == '0) && r_out_final)
        else $error("state not cleared after final word");

endmodule

`default_nettype wire

/* sv/sha512mp_ctrl_unused_guard.sv */
`default_nettype none

// consistency checker on the top-level ports only
module sha512mp_ctrl_unused_guard (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_end,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_final
);

    // an ending word stops intake until the final word is taken
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end |=> !i_in_ready)
        else $error("intake open right after end of message");

    // intake stays closed while the final word is on offer and stalled
    a_final_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_final |-> !i_in_ready || i_out_ready)
        else $error("intake during final word");

    // a stalled output word stays valid and keeps its final flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_final))
        else $error("stalled output word dropped");

endmodule

`default_nettype wire

/* sv/sha512_message_padder_core.sv */
// SHA-512 message padder. Message bytes enter one per word on the input
// channel and are packed big-endian into 64-bit words, each sent on the
// output channel when full; intake waits while the output slot is busy.
// A word with end_of_msg set (with or without a byte) starts padding: 0x80
// and zero bytes are packed one byte per cycle while the output slot is
// free, up to byte 112 of the 128-byte block, or of the next block when
// the message leaves no room there; then the 128-bit bit length follows as
// two words, high half first, and final_word marks the low half. Intake
// is closed during padding and length. An end byte that would complete a
// word at block position 104 is dropped so that its padding ends in the
// same block. The byte counter is COUNT_BITS wide and saturates. Reset is
// synchronous, active low.
`default_nettype none

module sha512_message_padder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sha512mp_in_if.sink      i_in,
    sha512mp_out_if.source   o_out
);

    sha512mp_pkg::t_cmd    cmd;
    sha512mp_pkg::t_status st;

    sha512mp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_end_of_msg (i_in.end_of_msg),
        .o_in_ready   (i_in.ready),
        .i_st         (st),
        .o_cmd        (cmd)
    );

    sha512mp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_msg_byte     (i_in.msg_byte),
        .i_byte_present (i_in.byte_present),
        .i_end_of_msg   (i_in.end_of_msg),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_padded_word  (o_out.padded_word),
        .o_final_word   (o_out.final_word),
        .i_cmd          (cmd),
        .o_st           (st)
    );

    sha512mp_ctrl_unused_guard u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_ready  (i_in.ready),
        .i_in_end    (i_in.end_of_msg),
        .i_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_out_final (o_out.final_word)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int N_ROWS      = 11;
    localparam int ITEM_TARGET = 310;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 200;
    localparam int SHOW_ERRORS = 10;

    // traffic shaping for each phase of the run
    typedef enum int {
        PH_FLOW,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_phase;

    // one expected output word
    typedef struct packed {
        logic [sha512mp_pkg::WORD_BITS-1:0] word;
        logic                               fin;
    } t_pad_word;

    // one row of the directed stimulus, repeated reps times
    typedef struct packed {
        logic [7:0]  data;
        logic        present;
        logic        eom;
        logic [7:0]  reps;
        logic        typed;
        logic [4:0]  exp_n;
        logic [63:0] exp_head;
        logic [63:0] exp_len;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    sha512mp_in_if  in_if ();
    sha512mp_out_if out_if ();

    sha512_message_padder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // padder state as predicted
    logic [sha512mp_pkg::COUNT_BITS-1:0] pad_count = '0;
    logic [sha512mp_pkg::BUF_BITS-1:0]   pad_buf   = '0;
    logic [sha512mp_pkg::FILL_BITS-1:0]  pad_fill  = '0;

    t_pad_word step_words [$];
    t_pad_word pad_words_q [$];
    t_stim_row dir_rows [0:N_ROWS-1];

    // side info that travels with the driven word
    logic drv_typed;
    int   drv_row;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    int n_items   = 0;
    int n_msgs    = 0;
    int n_checked = 0;
    int n_crossed = 0;
    int n_dropped = 0;
    int n_errors  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // pack one byte, emit the word when it is full
    function automatic void pad_push(input logic [7:0] b);
        t_pad_word w;
        if (pad_fill == sha512mp_pkg::FILL_LAST) begin
            w.word = {pad_buf, b};
            w.fin  = 1'b0;
            step_words.push_back(w);
            pad_buf  = '0;
            pad_fill = '0;
        end else begin
            pad_buf  = {pad_buf[sha512mp_pkg::BUF_BITS-9:0], b};
            pad_fill = pad_fill + 1'b1;
        end
    endfunction

    // words caused by one accepted input word
    function automatic void pad_step(input logic [7:0] data, input logic present,
                                     input logic eom);
        logic [sha512mp_pkg::POS_BITS-1:0] pos;
        logic [sha512mp_pkg::POS_BITS-1:0] target;
        t_pad_word                         w;
        step_words.delete();
        if (present) begin
            // end byte that would push padding into the next block is dropped
            if (eom && pad_fill == sha512mp_pkg::FILL_LAST
                    && pad_count[6:3] == sha512mp_pkg::OVF_GROUP) begin
                n_dropped++;
            end else begin
                pad_push(data);
                if (pad_count != '1)
                    pad_count = pad_count + 1'b1;
            end
        end
        if (eom) begin
            pos    = {1'b0, pad_count[6:3], pad_fill};
            target = (pos < sha512mp_pkg::LEN_POS) ? sha512mp_pkg::LEN_POS
                                                   : sha512mp_pkg::LEN_POS_NEXT;
            if (target == sha512mp_pkg::LEN_POS_NEXT)
                n_crossed++;
            pad_push(sha512mp_pkg::PAD_MARK);
            pos++;
            while (pos < target) begin
                pad_push(sha512mp_pkg::PAD_ZERO);
                pos++;
            end
            w.word = '0;
            w.fin  = 1'b0;
            step_words.push_back(w);
            w.word = {pad_count, 3'b000};
            w.fin  = 1'b1;
            step_words.push_back(w);
            pad_count = '0;
            pad_buf   = '0;
            pad_fill  = '0;
            n_msgs++;
        end
    endfunction

    function automatic void flag_error(input string what, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
        n_errors++;
        if (n_errors <= SHOW_ERRORS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    endfunction

    // predict on input accept, then check output accept
    always @(posedge i_clk) begin
        t_pad_word w;
        t_stim_row row;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                pad_step(in_if.msg_byte, in_if.byte_present, in_if.end_of_msg);
                if (drv_typed) begin
                    row    = dir_rows[drv_row];
                    w.word = row.exp_head;
                    w.fin  = 1'b0;
                    pad_words_q.push_back(w);
                    w.word = '0;
                    for (int i = 0; i < int'(row.exp_n) - 2; i++)
                        pad_words_q.push_back(w);
                    w.word = row.exp_len;
                    w.fin  = 1'b1;
                    pad_words_q.push_back(w);
                end else begin
                    foreach (step_words[i])
                        pad_words_q.push_back(step_words[i]);
                end
            end
            if (out_if.valid && out_if.ready) begin
                n_checked++;
                if (pad_words_q.size() == 0) begin
                    flag_error("unexpected word", '0, out_if.padded_word);
                end else begin
                    w = pad_words_q.pop_front();
                    if (out_if.padded_word !== w.word)
                        flag_error("padded_word", w.word, out_if.padded_word);
                    if (out_if.final_word !== w.fin)
                        flag_error("final_word", w.fin, out_if.final_word);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
                $display("** sha512_message_padder_core: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_phase(input t_phase ph);
        send_idle_pct  = (ph == PH_SEND_IDLE) ? 66 : (ph == PH_BOTH) ? 14 : 0;
        recv_stall_pct = (ph == PH_RECV_STALL) ? 66 : (ph == PH_BOTH) ? 14 : 0;
    endtask

    // offer one word and wait for it to be taken
    task automatic drive_item(input logic [7:0] data, input logic present,
                              input logic eom, input logic typed, input int row);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid        = 1'b1;
        in_if.msg_byte     = data;
        in_if.byte_present = present;
        in_if.end_of_msg   = eom;
        drv_typed          = typed;
        drv_row            = row;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (present || eom)
            n_items++;
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        drv_typed   = 1'b0;
    endtask

    task automatic wait_drained();
        while (pad_words_q.size() != 0)
            @(posedge i_clk);
    endtask

    // message of len bytes with stray empty words mixed in
    task automatic send_message(input int len, input logic end_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8)
                drive_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 0);
            drive_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 0);
        end
        drive_item(8'($urandom_range(255)), end_byte, 1'b1, 1'b0, 0);
    endtask

    // stimulus
    initial begin
        int     msg_cnt;
        int     pick;
        int     len;
        t_stim_row row;

        in_if.valid        = 1'b0;
        in_if.msg_byte     = '0;
        in_if.byte_present = 1'b0;
        in_if.end_of_msg   = 1'b0;
        drv_typed          = 1'b0;
        drv_row            = 0;
        i_rst_n            = 1'b0;

        // empty message, one-byte messages at the byte extremes
        dir_rows[0]  = '{8'h00, 1'b0, 1'b1, 8'd1, 1'b1, 5'd16,
                         64'h8000_0000_0000_0000, 64'd0};
        dir_rows[1]  = '{8'hFF, 1'b1, 1'b1, 8'd1, 1'b1, 5'd16,
                         64'hFF80_0000_0000_0000, 64'd8};
        dir_rows[2]  = '{8'h00, 1'b1, 1'b1, 8'd1, 1'b1, 5'd16,
                         64'h0080_0000_0000_0000, 64'd8};
        // stray word that carries nothing
        dir_rows[3]  = '{8'hA5, 1'b0, 1'b0, 8'd1, 1'b0, 5'd0, 64'd0, 64'd0};
        // one full word, then end with no byte
        dir_rows[4]  = '{8'h55, 1'b1, 1'b0, 8'd7, 1'b0, 5'd0, 64'd0, 64'd0};
        dir_rows[5]  = '{8'hAA, 1'b1, 1'b0, 8'd1, 1'b0, 5'd0, 64'd0, 64'd0};
        dir_rows[6]  = '{8'h00, 1'b0, 1'b1, 8'd1, 1'b0, 5'd0, 64'd0, 64'd0};
        // end byte completes a word
        dir_rows[7]  = '{8'hFF, 1'b1, 1'b0, 8'd7, 1'b0, 5'd0, 64'd0, 64'd0};
        dir_rows[8]  = '{8'h7E, 1'b1, 1'b1, 8'd1, 1'b0, 5'd0, 64'd0, 64'd0};
        // end mid-word without a byte
        dir_rows[9]  = '{8'h81, 1'b1, 1'b0, 8'd3, 1'b0, 5'd0, 64'd0, 64'd0};
        dir_rows[10] = '{8'h5A, 1'b0, 1'b1, 8'd1, 1'b0, 5'd0, 64'd0, 64'd0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        set_phase(PH_FLOW);
        for (int r = 0; r < N_ROWS; r++) begin
            row = dir_rows[r];
            for (int k = 0; k < int'(row.reps); k++)
                drive_item(row.data, row.present, row.eom, row.typed, r);
        end
        idle_sender();
        wait_drained();

        // dropped end byte, with the output held off long enough to back up input
        hold_req = 1'b1;
        send_message(111, 1'b1);
        // padding that runs into the next block
        set_phase(PH_BOTH);
        send_message(112, 1'b0);

        // random messages, mostly short
        msg_cnt = 0;
        while (n_items < ITEM_TARGET) begin
            set_phase(t_phase'((msg_cnt / 2) % 4));
            if (msg_cnt == 6) begin
                idle_sender();
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(15);
            else if (pick < 97)
                len = $urandom_range(40, 16);
            else
                len = $urandom_range(127, 100);
            send_message(len, 1'($urandom_range(1)));
            msg_cnt++;
        end
        idle_sender();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pad_words_q.size() != 0) begin
            n_errors++;
            $display("%0d expected words never arrived", pad_words_q.size());
        end
        $display("covered %0d messages from %0d input words, %0d padded words checked",
                 n_msgs, n_items, n_checked);
        $display("%0d pads into the next block, %0d dropped end bytes, %0d mismatches",
                 n_crossed, n_dropped, n_errors);
        if (n_errors == 0) begin
            $display("** sha512_message_padder_core: PASSED **");
        end else begin
            $display("** sha512_message_padder_core: FAILED **");
        end
        $finish;
    end

endmodule
